### hw/rtl/pngse_pkg.sv
// ----------------------------------------------------------------------------
// pngse_pkg
// Shared types and constants of the stored-deflate PNG encoder.
// ----------------------------------------------------------------------------
package pngse_pkg;

    localparam int BLOCK_MAX  = 65535;
    localparam int MAX_EXTENT = 16384;

    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    // one classified input transaction
    typedef struct packed {
        logic [7:0]  data;
        logic        open;
        logic        filt;
        logic        img;
        logic        hdr;
        logic        hdr_at_img;
        logic        close;
        logic [30:0] hdr_rem;
    } item_t;

    // extents and payload total fixed when a file opens
    typedef struct packed {
        logic [14:0] width;
        logic [14:0] height;
        logic [30:0] total;
    } file_info_t;

endpackage

### hw/rtl/png_stored_deflate_encoder_top.sv
// ----------------------------------------------------------------------------
// png_stored_deflate_encoder_top
// RGBA8 image bytes in, complete PNG file (stored deflate blocks) out.
// ----------------------------------------------------------------------------
// The output side moves one stream byte per cycle while out_stall is low and
// a transaction is held. An input transaction is taken per cycle as long as
// the two-entry queue between classifier and byte sequencer has room; the
// sequencer is the bottleneck, and an image byte yields one stream byte, two
// at a scanline start, plus five for each stored-block header, 43 for the
// file header on the first byte and 20 for the trailer on the last. The header
// extents and the payload total are sampled when the first byte of a file is
// taken; the scanline length follows the current width register.
// ----------------------------------------------------------------------------
module png_stored_deflate_encoder_top
    import pngse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pixel_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        file_end
);

    logic [14:0] image_width_reg;
    logic [14:0] image_height_reg;

    logic        push;
    item_t       push_item;
    logic        q_full;
    logic        pop;
    logic        q_not_empty;
    item_t       q_head;
    file_info_t  file_info;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 15'd1;
            image_height_reg <= 15'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    pngse_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .in_valid     (in_valid),
        .pixel_byte   (pixel_byte),
        .in_stall     (in_stall),
        .q_full       (q_full),
        .push         (push),
        .push_item    (push_item),
        .file_info    (file_info)
    );

    pngse_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    pngse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .file_info   (file_info),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .file_end    (file_end)
    );

endmodule

### hw/rtl/pngse_fifo.sv
// ----------------------------------------------------------------------------
// pngse_fifo
// Two-entry queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module pngse_fifo
    import pngse_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### hw/rtl/pngse_front.sv
// ----------------------------------------------------------------------------
// pngse_front
// Accepts image bytes and works out which stream segments each one causes.
// ----------------------------------------------------------------------------
module pngse_front
    import pngse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [14:0] image_width,
    input  logic [14:0] image_height,
    input  logic        in_valid,
    input  logic [7:0]  pixel_byte,
    output logic        in_stall,
    input  logic        q_full,
    output logic        push,
    output item_t       push_item,
    output file_info_t  file_info
);

    logic        header_sent_reg;
    logic [30:0] payload_rem_reg;
    logic [15:0] block_rem_reg;
    logic [16:0] col_reg;
    file_info_t  file_info_reg;

    logic [14:0] w_c;
    logic [14:0] h_c;
    logic [16:0] stride;
    logic [30:0] total_c;
    logic [30:0] pr;
    logic [15:0] br;
    logic [16:0] col;
    item_t       it;

    function automatic logic [14:0] clamp(input logic [14:0] v);
        if (v == 15'd0)
        begin
            return 15'd1;
        end
        if (v > 15'(MAX_EXTENT))
        begin
            return 15'(MAX_EXTENT);
        end
        return v;
    endfunction

    function automatic logic [15:0] block_len(input logic [30:0] rem);
        return (rem > 31'(BLOCK_MAX)) ? 16'(BLOCK_MAX) : rem[15:0];
    endfunction

    assign in_stall  = q_full;
    assign push      = in_valid && !q_full;
    assign push_item = it;
    assign file_info = file_info_reg;

    always_comb
    begin
        w_c     = clamp(image_width);
        h_c     = clamp(image_height);
        stride  = {w_c, 2'b00};
        total_c = 31'(h_c * (stride + 17'd1));

        pr  = header_sent_reg ? payload_rem_reg : total_c;
        br  = header_sent_reg ? block_rem_reg : 16'd0;
        col = header_sent_reg ? col_reg : 17'd0;

        it            = '0;
        it.data       = pixel_byte;
        it.open       = !header_sent_reg;

        if (col == 17'd0 && pr != 31'd0)
        begin
            it.filt = 1'b1;
            if (br == 16'd0)
            begin
                it.hdr     = 1'b1;
                it.hdr_rem = pr;
                br         = block_len(pr);
            end
            br = br - 16'd1;
            pr = pr - 31'd1;
        end

        if (pr != 31'd0)
        begin
            it.img = 1'b1;
            if (br == 16'd0)
            begin
                it.hdr        = 1'b1;
                it.hdr_at_img = 1'b1;
                it.hdr_rem    = pr;
                br            = block_len(pr);
            end
            br  = br - 16'd1;
            pr  = pr - 31'd1;
            col = col + 17'd1;
            if (col >= stride)
            begin
                col = 17'd0;
            end
        end

        it.close = (pr == 31'd0);
    end

    always_ff @(posedge clk)
    begin
        if (push && !header_sent_reg)
        begin
            file_info_reg <= '{width: w_c, height: h_c, total: total_c};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_sent_reg <= 1'b0;
            payload_rem_reg <= '0;
            block_rem_reg   <= '0;
            col_reg         <= '0;
        end
        else if (push)
        begin
            if (it.close)
            begin
                header_sent_reg <= 1'b0;
                payload_rem_reg <= '0;
                block_rem_reg   <= '0;
                col_reg         <= '0;
            end
            else
            begin
                header_sent_reg <= 1'b1;
                payload_rem_reg <= pr;
                block_rem_reg   <= br;
                col_reg         <= col;
            end
        end
    end

endmodule

### hw/rtl/pngse_back.sv
// ----------------------------------------------------------------------------
// pngse_back
// Byte sequencer: expands queued transactions into PNG stream bytes and keeps
// the running CRC-32 and Adler-32.
// ----------------------------------------------------------------------------
module pngse_back
    import pngse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  item_t      q_head,
    output logic       pop,
    input  file_info_t file_info,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       file_end
);

    localparam logic [2:0] PH_OPEN  = 3'd0;
    localparam logic [2:0] PH_HDRF  = 3'd1;
    localparam logic [2:0] PH_FILT  = 3'd2;
    localparam logic [2:0] PH_HDRI  = 3'd3;
    localparam logic [2:0] PH_IMG   = 3'd4;
    localparam logic [2:0] PH_CLOSE = 3'd5;
    localparam logic [2:0] PH_NONE  = 3'd7;

    localparam logic [63:0] PNG_SIG  = 64'h89504E470D0A1A0A;
    localparam logic [31:0] TAG_IHDR = 32'h49484452;
    localparam logic [31:0] TAG_IDAT = 32'h49444154;
    localparam logic [31:0] TAG_IEND = 32'h49454E44;
    localparam logic [31:0] IEND_CRC = 32'hAE426082;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [15:0] ADLER_MOD = 16'd65521;

    item_t       cur_reg;
    logic        cur_valid_reg;
    logic [2:0]  phase_reg;
    logic [5:0]  idx_reg;
    logic [31:0] crc_reg;
    logic [15:0] adler_lo_reg;
    logic [15:0] adler_hi_reg;
    logic [14:0] width_reg;
    logic [14:0] height_reg;
    logic [31:0] idat_len_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        run_last_reg;
    logic        file_end_reg;

    logic        advance;
    logic [5:0]  phase_last;
    logic        last_in_phase;
    logic [2:0]  nxt_phase;
    logic        last_of_item;
    logic [7:0]  byte_c;
    logic        crc_en;
    logic        crc_init;
    logic        adler_en;
    logic [31:0] crc_next;
    logic [16:0] lo_sum;
    logic [15:0] lo_next;
    logic [16:0] hi_sum;
    logic [15:0] hi_next;
    logic [15:0] hdr_len;
    logic [1:0]  sel;
    logic [16:0] blk_s;
    logic [1:0]  blk_extra;
    logic [15:0] blocks;
    logic [31:0] idat_c;

    function automatic logic [5:0] phase_mask(input item_t e);
        return {e.close, e.img, e.hdr && e.hdr_at_img, e.filt,
                e.hdr && !e.hdr_at_img, e.open};
    endfunction

    // lowest segment of the transaction that comes after ph
    function automatic logic [2:0] after_phase(input item_t e, input logic [2:0] ph,
                                               input logic from_start);
        logic [5:0] m;
        logic [2:0] res;
        m   = phase_mask(e);
        res = PH_NONE;
        for (int i = 5; i >= 0; i--)
        begin
            if (m[i] && (from_start || 3'(i) > ph))
            begin
                res = 3'(i);
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] byte_sel(input logic [31:0] w, input logic [1:0] s);
        case (s)
            2'd0:    return w[31:24];
            2'd1:    return w[23:16];
            2'd2:    return w[15:8];
            default: return w[7:0];
        endcase
    endfunction

    function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign file_end  = file_end_reg;

    assign advance = cur_valid_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        case (phase_reg)
            PH_OPEN:  phase_last = 6'd42;
            PH_HDRF:  phase_last = 6'd4;
            PH_HDRI:  phase_last = 6'd4;
            PH_CLOSE: phase_last = 6'd19;
            default:  phase_last = 6'd0;
        endcase
    end

    assign last_in_phase = (idx_reg == phase_last);
    assign nxt_phase     = after_phase(cur_reg, phase_reg, 1'b0);
    assign last_of_item  = last_in_phase && (nxt_phase == PH_NONE);
    assign pop = q_not_empty && (!cur_valid_reg || (advance && last_of_item));

    // IDAT length: 2 + 5 * ceil(total / 65535) + total + 4
    always_comb
    begin
        blk_s = {2'b00, file_info.total[30:16]} + {1'b0, file_info.total[15:0]};
        if (blk_s == 17'd0)
        begin
            blk_extra = 2'd0;
        end
        else if (blk_s <= 17'(BLOCK_MAX))
        begin
            blk_extra = 2'd1;
        end
        else
        begin
            blk_extra = 2'd2;
        end
        blocks = {1'b0, file_info.total[30:16]} + {14'd0, blk_extra};
        idat_c = {1'b0, file_info.total} + {14'd0, blocks, 2'b00} + {16'd0, blocks}
                 + 32'd6;
    end

    assign hdr_len = (cur_reg.hdr_rem > 31'(BLOCK_MAX)) ? 16'(BLOCK_MAX)
                                                      : cur_reg.hdr_rem[15:0];

    always_comb
    begin
        byte_c   = 8'd0;
        crc_en   = 1'b0;
        crc_init = 1'b0;
        adler_en = 1'b0;
        sel      = idx_reg[1:0];
        case (phase_reg)
            PH_OPEN:
            begin
                if (idx_reg <= 6'd7)
                begin
                    byte_c = PNG_SIG[8'(7 - idx_reg[2:0]) * 8 +: 8];
                end
                else if (idx_reg <= 6'd11)
                begin
                    byte_c = byte_sel(32'd13, sel);
                end
                else if (idx_reg <= 6'd15)
                begin
                    byte_c   = byte_sel(TAG_IHDR, sel);
                    crc_en   = 1'b1;
                    crc_init = (idx_reg == 6'd12);
                end
                else if (idx_reg <= 6'd19)
                begin
                    byte_c = byte_sel({17'd0, width_reg}, sel);
                    crc_en = 1'b1;
                end
                else if (idx_reg <= 6'd23)
                begin
                    byte_c = byte_sel({17'd0, height_reg}, sel);
                    crc_en = 1'b1;
                end
                else if (idx_reg <= 6'd28)
                begin
                    crc_en = 1'b1;
                    if (idx_reg == 6'd24)
                    begin
                        byte_c = 8'd8;
                    end
                    else if (idx_reg == 6'd25)
                    begin
                        byte_c = 8'd6;
                    end
                end
                else if (idx_reg <= 6'd32)
                begin
                    byte_c = byte_sel(~crc_reg, 2'(idx_reg - 6'd29));
                end
                else if (idx_reg <= 6'd36)
                begin
                    byte_c = byte_sel(idat_len_reg, 2'(idx_reg - 6'd33));
                end
                else if (idx_reg <= 6'd40)
                begin
                    byte_c   = byte_sel(TAG_IDAT, 2'(idx_reg - 6'd37));
                    crc_en   = 1'b1;
                    crc_init = (idx_reg == 6'd37);
                end
                else
                begin
                    byte_c = (idx_reg == 6'd41) ? 8'h78 : 8'h01;
                    crc_en = 1'b1;
                end
            end
            PH_HDRF, PH_HDRI:
            begin
                crc_en = 1'b1;
                case (idx_reg[2:0])
                    3'd0:    byte_c = {7'd0, !(cur_reg.hdr_rem > 31'(BLOCK_MAX))};
                    3'd1:    byte_c = hdr_len[7:0];
                    3'd2:    byte_c = hdr_len[15:8];
                    3'd3:    byte_c = ~hdr_len[7:0];
                    default: byte_c = ~hdr_len[15:8];
                endcase
            end
            PH_FILT:
            begin
                crc_en   = 1'b1;
                adler_en = 1'b1;
            end
            PH_IMG:
            begin
                byte_c   = cur_reg.data;
                crc_en   = 1'b1;
                adler_en = 1'b1;
            end
            PH_CLOSE:
            begin
                case (idx_reg[4:2])
                    3'd0:
                    begin
                        byte_c = byte_sel({adler_hi_reg, adler_lo_reg}, sel);
                        crc_en = 1'b1;
                    end
                    3'd1:    byte_c = byte_sel(~crc_reg, sel);
                    3'd2:    byte_c = 8'd0;
                    3'd3:    byte_c = byte_sel(TAG_IEND, sel);
                    default: byte_c = byte_sel(IEND_CRC, sel);
                endcase
            end
            default:
            begin
                byte_c = 8'd0;
            end
        endcase
    end

    assign crc_next = crc_step(crc_init ? 32'hFFFFFFFF : crc_reg, byte_c);

    always_comb
    begin
        lo_sum  = {1'b0, adler_lo_reg} + {9'd0, byte_c};
        lo_next = (lo_sum >= {1'b0, ADLER_MOD}) ? 16'(lo_sum - {1'b0, ADLER_MOD})
                                                : lo_sum[15:0];
        hi_sum  = {1'b0, adler_hi_reg} + {1'b0, lo_next};
        hi_next = (hi_sum >= {1'b0, ADLER_MOD}) ? 16'(hi_sum - {1'b0, ADLER_MOD})
                                                : hi_sum[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_head;
            if (q_head.open)
            begin
                width_reg    <= file_info.width;
                height_reg   <= file_info.height;
                idat_len_reg <= idat_c;
            end
        end
        if (advance)
        begin
            out_byte_reg <= byte_c;
            run_last_reg <= last_of_item;
            file_end_reg <= last_in_phase && (phase_reg == PH_CLOSE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= PH_NONE;
            idx_reg       <= '0;
            crc_reg       <= 32'hFFFFFFFF;
            adler_lo_reg  <= 16'd1;
            adler_hi_reg  <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                if (crc_en)
                begin
                    crc_reg <= crc_next;
                end
                if (phase_reg == PH_OPEN && idx_reg == 6'd0)
                begin
                    adler_lo_reg <= 16'd1;
                    adler_hi_reg <= 16'd0;
                end
                else if (adler_en)
                begin
                    adler_lo_reg <= lo_next;
                    adler_hi_reg <= hi_next;
                end
            end

            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                phase_reg     <= after_phase(q_head, PH_NONE, 1'b1);
                idx_reg       <= '0;
            end
            else if (advance)
            begin
                if (last_of_item)
                begin
                    cur_valid_reg <= 1'b0;
                end
                else if (last_in_phase)
                begin
                    phase_reg <= nxt_phase;
                    idx_reg   <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 6'd1;
                end
            end
        end
    end

endmodule
